[hw/rtl/qrpg_pkg.sv]
// Shared constants for the quaternion to roll/pitch/gravity pipeline.
// Arctangent table, angle formats and output limits. No dependencies.
`timescale 1ns / 1ps

package qrpg_pkg;

  // Angle accumulator: Q30 radians, wide enough for pi/2 plus the table sum
  localparam int ANG_FRAC  = 30;
  localparam int OUT_FRAC  = 13;
  localparam int OUT_SHIFT = ANG_FRAC - OUT_FRAC;
  localparam int ANG_W     = 33;

  // Integer square root: 61-bit radicand, one root bit per cell
  localparam int SQRT_W     = 62;
  localparam int SQRT_STEPS = 31;
  localparam int ROOT_W     = 31;

  localparam int TAB_LEN = 24;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [ANG_W-1:0] ROLL_MAX    = 33'sd25736;
  localparam logic signed [ANG_W-1:0] PITCH_MAX   = 33'sd12868;

  // atan(2^-i), Q30, truncated
  localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149,
    30'd1048575,   30'd524287,    30'd262143,    30'd131071,    30'd65535,
    30'd32767,     30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

endpackage

[hw/rtl/qrpg_front.sv]
// Front end: quaternion products, gravity rounding, CORDIC operand prep
// and the square-root radicand. Three register stages. Uses qrpg_pkg.
`timescale 1ns / 1ps

module qrpg_front #(
  parameter int FRAC_BITS = 14,
  parameter int SUM_W     = 35,
  parameter int CW        = 39
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  logic signed [15:0]                   quat_x,
  input  logic signed [15:0]                   quat_y,
  input  logic signed [15:0]                   quat_z,
  input  logic signed [15:0]                   quat_w,
  output logic                                 vld_o,
  output logic signed [15:0]                   grav_x_o,
  output logic signed [15:0]                   grav_y_o,
  output logic signed [15:0]                   grav_z_o,
  output logic signed [CW-1:0]                 roll_x_o,
  output logic signed [CW-1:0]                 roll_y_o,
  output logic signed [qrpg_pkg::ANG_W-1:0]    roll_ang_o,
  output logic                                 roll_zero_o,
  output logic signed [31:0]                   pitch_sn_o,
  output logic [qrpg_pkg::SQRT_W-1:0]          rad_o
);

  localparam int SH_L = (2 * FRAC_BITS < qrpg_pkg::ANG_FRAC) ?
                        qrpg_pkg::ANG_FRAC - 2 * FRAC_BITS : 0;
  localparam int SH_R = (2 * FRAC_BITS > qrpg_pkg::ANG_FRAC) ?
                        2 * FRAC_BITS - qrpg_pkg::ANG_FRAC : 0;
  localparam logic signed [SUM_W-1:0] ONE   = SUM_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] G_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] G_MIN = SUM_W'(-32768);

  // stage A: products
  logic               va_r;
  logic signed [31:0] xx_r, yy_r, xz_r, wy_r, yz_r, wx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= 32'(quat_x) * 32'(quat_x);
      yy_r <= 32'(quat_y) * 32'(quat_y);
      xz_r <= 32'(quat_x) * 32'(quat_z);
      wy_r <= 32'(quat_w) * 32'(quat_y);
      yz_r <= 32'(quat_y) * 32'(quat_z);
      wx_r <= 32'(quat_w) * 32'(quat_x);
    end
  end

  // stage B: sums, gravity, angle operands
  function automatic logic signed [15:0] grav_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    if (t > G_MAX) begin
      t = G_MAX;
    end else if (t < G_MIN) begin
      t = G_MIN;
    end
    return t[15:0];
  endfunction

  logic signed [SUM_W-1:0] sq, d1x2, d2x2, gz_f, rx_f, s_c;
  logic signed [CW-1:0]    rx_q, ry_q, sn_q;

  always_comb begin
    sq   = SUM_W'(xx_r) + SUM_W'(yy_r);
    d1x2 = (SUM_W'(wy_r) - SUM_W'(xz_r)) <<< 1;   // 2(wy - xz)
    d2x2 = (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;   // 2(wx + yz)
    gz_f = (sq <<< 1) - ONE;
    rx_f = ONE - (sq <<< 1);
    if (d1x2 > ONE) begin
      s_c = ONE;
    end else if (d1x2 < -ONE) begin
      s_c = -ONE;
    end else begin
      s_c = d1x2;
    end
    ry_q = (CW'(d2x2) <<< SH_L) >>> SH_R;
    rx_q = (CW'(rx_f) <<< SH_L) >>> SH_R;
    sn_q = (CW'(s_c) <<< SH_L) >>> SH_R;
  end

  logic               vb_r;
  logic signed [15:0] gx_r, gy_r, gz_r;
  logic signed [CW-1:0] rx_r, ry_r;
  logic signed [31:0] sn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= grav_sat(d1x2);
      gy_r <= grav_sat(-d2x2);
      gz_r <= grav_sat(gz_f);
      rx_r <= rx_q;
      ry_r <= ry_q;
      sn_r <= sn_q[31:0];
    end
  end

  // stage C: radicand 1 - s^2 and left half-plane fold for roll
  logic [31:0]                        mag_full;
  logic [qrpg_pkg::ROOT_W-1:0]        mag;
  logic [qrpg_pkg::SQRT_W-1:0]        mag_sq, rad_c;
  logic signed [CW-1:0]               nx, ny;
  logic signed [qrpg_pkg::ANG_W-1:0]  ang0;
  logic                               zero_c;

  always_comb begin
    mag_full = sn_r[31] ? 32'(-sn_r) : 32'(sn_r);
    mag      = mag_full[qrpg_pkg::ROOT_W-1:0];
    mag_sq   = qrpg_pkg::SQRT_W'(mag) * qrpg_pkg::SQRT_W'(mag);
    rad_c    = (qrpg_pkg::SQRT_W'(1) << (2 * qrpg_pkg::ANG_FRAC)) - mag_sq;
    zero_c   = (rx_r == '0) && (ry_r == '0);
    if (rx_r < 0) begin
      if (ry_r >= 0) begin
        nx   = ry_r;
        ny   = -rx_r;
        ang0 = qrpg_pkg::HALF_PI_Q30;
      end else begin
        nx   = -ry_r;
        ny   = rx_r;
        ang0 = -qrpg_pkg::HALF_PI_Q30;
      end
    end else begin
      nx   = rx_r;
      ny   = ry_r;
      ang0 = '0;
    end
  end

  logic vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grav_x_o    <= gx_r;
      grav_y_o    <= gy_r;
      grav_z_o    <= gz_r;
      roll_x_o    <= nx;
      roll_y_o    <= ny;
      roll_ang_o  <= ang0;
      roll_zero_o <= zero_c;
      pitch_sn_o  <= sn_r;
      rad_o       <= rad_c;
    end
  end

  assign vld_o = vc_r;

endmodule

[hw/rtl/qrpg_sqrt_cell.sv]
// One cell of the integer square-root chain: one root bit per cell.
// Carries a side word alongside. Uses qrpg_pkg.
`timescale 1ns / 1ps

module qrpg_sqrt_cell #(
  parameter int K      = 0,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic [qrpg_pkg::SQRT_W-1:0]  n_i,
  input  logic [qrpg_pkg::SQRT_W-1:0]  res_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         vld_o,
  output logic [qrpg_pkg::SQRT_W-1:0]  n_o,
  output logic [qrpg_pkg::SQRT_W-1:0]  res_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam logic [qrpg_pkg::SQRT_W-1:0] BIT = qrpg_pkg::SQRT_W'(1) << (2 * K);

  logic [qrpg_pkg::SQRT_W-1:0] trial, n_nxt, res_nxt;
  logic                        take;

  always_comb begin
    trial   = res_i + BIT;
    take    = (n_i >= trial);
    n_nxt   = take ? n_i - trial : n_i;
    res_nxt = take ? (res_i >> 1) + BIT : (res_i >> 1);
  end

  logic                        vld_r;
  logic [qrpg_pkg::SQRT_W-1:0] n_r, res_r;
  logic [SIDE_W-1:0]           side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      res_r  <= res_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign n_o    = n_r;
  assign res_o  = res_r;
  assign side_o = side_r;

endmodule

[hw/rtl/qrpg_cordic_cell.sv]
// One CORDIC vectoring micro-rotation for the roll and pitch lanes.
// Carries a side word alongside. Uses qrpg_pkg.
`timescale 1ns / 1ps

module qrpg_cordic_cell #(
  parameter int IDX    = 0,
  parameter int CW     = 39,
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               vld_i,
  input  logic signed [CW-1:0]               x_i   [2],
  input  logic signed [CW-1:0]               y_i   [2],
  input  logic signed [qrpg_pkg::ANG_W-1:0]  ang_i [2],
  input  logic [SIDE_W-1:0]                  side_i,
  output logic                               vld_o,
  output logic signed [CW-1:0]               x_o   [2],
  output logic signed [CW-1:0]               y_o   [2],
  output logic signed [qrpg_pkg::ANG_W-1:0]  ang_o [2],
  output logic [SIDE_W-1:0]                  side_o
);

  localparam logic signed [qrpg_pkg::ANG_W-1:0] STEP =
    $signed(qrpg_pkg::ANG_W'(qrpg_pkg::ATAN_TAB[IDX]));

  logic signed [CW-1:0]              x_nxt [2];
  logic signed [CW-1:0]              y_nxt [2];
  logic signed [qrpg_pkg::ANG_W-1:0] a_nxt [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (y_i[l] >= 0) begin
        x_nxt[l] = x_i[l] + (y_i[l] >>> IDX);
        y_nxt[l] = y_i[l] - (x_i[l] >>> IDX);
        a_nxt[l] = ang_i[l] + STEP;
      end else begin
        x_nxt[l] = x_i[l] - (y_i[l] >>> IDX);
        y_nxt[l] = y_i[l] + (x_i[l] >>> IDX);
        a_nxt[l] = ang_i[l] - STEP;
      end
    end
  end

  logic                              vld_r;
  logic signed [CW-1:0]              x_r [2];
  logic signed [CW-1:0]              y_r [2];
  logic signed [qrpg_pkg::ANG_W-1:0] a_r [2];
  logic [SIDE_W-1:0]                 side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      a_r    <= a_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign ang_o  = a_r;
  assign side_o = side_r;

endmodule

[hw/rtl/quaternion_to_roll_pitch_gravity.sv]
// Quaternion to projected gravity, roll and pitch; fully pipelined.
// Stages: 3 front stages, 31 square-root cells, CORDIC_STAGES rotation
// cells, 1 output register. Throughput: one word per cycle; the whole
// chain stalls while out_valid is high and out_ready is low.
// Reset clears the valid bits only; payload registers are not reset.
`timescale 1ns / 1ps

module quaternion_to_roll_pitch_gravity #(
  parameter int CORDIC_STAGES = 16,   // 8..24
  parameter int FRAC_BITS     = 14    // 10..20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_grav_x,
  output logic signed [15:0] out_grav_y,
  output logic signed [15:0] out_grav_z,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle
);

  localparam int AW    = qrpg_pkg::ANG_W;
  localparam int NS    = qrpg_pkg::SQRT_STEPS;
  localparam int SQW   = qrpg_pkg::SQRT_W;
  // exact sums carry 2*FRAC_BITS fraction bits plus a few integer bits
  localparam int SUM_W = (2 * FRAC_BITS + 2 > 35) ? 2 * FRAC_BITS + 2 : 35;
  localparam int SH_L  = (2 * FRAC_BITS < qrpg_pkg::ANG_FRAC) ?
                         qrpg_pkg::ANG_FRAC - 2 * FRAC_BITS : 0;
  // CORDIC datapath: Q30 operand plus headroom for gain and half-plane fold
  localparam int CW    = SUM_W + SH_L + 2;
  localparam int GRAV_W = 48;
  // side word through the root chain: gravity, zero flag, roll x/y/angle, pitch s
  localparam int SIDE_S = GRAV_W + 1 + 2 * CW + AW + 32;
  // side word through the CORDIC chain: gravity, zero flag
  localparam int SIDE_C = GRAV_W + 1;

  localparam logic signed [AW-1:0] ANG_RND = AW'(1) << (qrpg_pkg::OUT_SHIFT - 1);

  // Global advance: the chain moves when the output register is free or drained.
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ---------------- front stages ----------------
  logic               f_vld;
  logic signed [15:0] f_gx, f_gy, f_gz;
  logic signed [CW-1:0] f_rx, f_ry;
  logic signed [AW-1:0] f_ang;
  logic               f_zero;
  logic signed [31:0] f_sn;
  logic [SQW-1:0]     f_rad;

  qrpg_front #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W),
    .CW        (CW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .vld_i       (in_valid),
    .quat_x      (in_quat_x),
    .quat_y      (in_quat_y),
    .quat_z      (in_quat_z),
    .quat_w      (in_quat_w),
    .vld_o       (f_vld),
    .grav_x_o    (f_gx),
    .grav_y_o    (f_gy),
    .grav_z_o    (f_gz),
    .roll_x_o    (f_rx),
    .roll_y_o    (f_ry),
    .roll_ang_o  (f_ang),
    .roll_zero_o (f_zero),
    .pitch_sn_o  (f_sn),
    .rad_o       (f_rad)
  );

  // ---------------- square-root chain: cos(pitch) = sqrt(1 - s^2) ----------------
  logic [NS:0]       s_vld;
  logic [SQW-1:0]    s_n    [NS+1];
  logic [SQW-1:0]    s_res  [NS+1];
  logic [SIDE_S-1:0] s_side [NS+1];

  assign s_vld[0]  = f_vld;
  assign s_n[0]    = f_rad;
  assign s_res[0]  = '0;
  assign s_side[0] = {f_gx, f_gy, f_gz, f_zero, f_rx, f_ry, f_ang, f_sn};

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    qrpg_sqrt_cell #(
      .K      (NS - 1 - j),
      .SIDE_W (SIDE_S)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (s_vld[j]),
      .n_i    (s_n[j]),
      .res_i  (s_res[j]),
      .side_i (s_side[j]),
      .vld_o  (s_vld[j+1]),
      .n_o    (s_n[j+1]),
      .res_o  (s_res[j+1]),
      .side_o (s_side[j+1])
    );
  end

  // unpack the side word at the end of the root chain
  logic [GRAV_W-1:0]    q_grav;
  logic                 q_zero;
  logic signed [CW-1:0] q_rx, q_ry;
  logic signed [AW-1:0] q_ang;
  logic signed [31:0]   q_sn;

  assign {q_grav, q_zero, q_rx, q_ry, q_ang, q_sn} = s_side[NS];

  // ---------------- CORDIC chain: lane 0 roll, lane 1 pitch ----------------
  logic [CORDIC_STAGES:0] c_vld;
  logic signed [CW-1:0]   c_x   [CORDIC_STAGES+1][2];
  logic signed [CW-1:0]   c_y   [CORDIC_STAGES+1][2];
  logic signed [AW-1:0]   c_ang [CORDIC_STAGES+1][2];
  logic [SIDE_C-1:0]      c_side [CORDIC_STAGES+1];

  assign c_vld[0]    = s_vld[NS];
  assign c_x[0][0]   = q_rx;
  assign c_y[0][0]   = q_ry;
  assign c_ang[0][0] = q_ang;
  assign c_x[0][1]   = $signed({{(CW - qrpg_pkg::ROOT_W){1'b0}},
                                s_res[NS][qrpg_pkg::ROOT_W-1:0]});
  assign c_y[0][1]   = CW'(q_sn);
  assign c_ang[0][1] = '0;
  assign c_side[0]   = {q_grav, q_zero};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qrpg_cordic_cell #(
      .IDX    (i),
      .CW     (CW),
      .SIDE_W (SIDE_C)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (c_vld[i]),
      .x_i    (c_x[i]),
      .y_i    (c_y[i]),
      .ang_i  (c_ang[i]),
      .side_i (c_side[i]),
      .vld_o  (c_vld[i+1]),
      .x_o    (c_x[i+1]),
      .y_o    (c_y[i+1]),
      .ang_o  (c_ang[i+1]),
      .side_o (c_side[i+1])
    );
  end

  // ---------------- output stage: round to Q3.13 and clamp ----------------
  logic [GRAV_W-1:0]   e_grav;
  logic                e_zero;
  logic signed [AW-1:0] r_rnd, p_rnd, r_cl, p_cl;

  assign {e_grav, e_zero} = c_side[CORDIC_STAGES];

  always_comb begin
    r_rnd = (c_ang[CORDIC_STAGES][0] + ANG_RND) >>> qrpg_pkg::OUT_SHIFT;
    p_rnd = (c_ang[CORDIC_STAGES][1] + ANG_RND) >>> qrpg_pkg::OUT_SHIFT;
    if (e_zero) begin
      r_cl = '0;                      // atan2(0, 0) is defined as 0
    end else if (r_rnd > qrpg_pkg::ROLL_MAX) begin
      r_cl = qrpg_pkg::ROLL_MAX;
    end else if (r_rnd < -qrpg_pkg::ROLL_MAX) begin
      r_cl = -qrpg_pkg::ROLL_MAX;
    end else begin
      r_cl = r_rnd;
    end
    if (p_rnd > qrpg_pkg::PITCH_MAX) begin
      p_cl = qrpg_pkg::PITCH_MAX;
    end else if (p_rnd < -qrpg_pkg::PITCH_MAX) begin
      p_cl = -qrpg_pkg::PITCH_MAX;
    end else begin
      p_cl = p_rnd;
    end
  end

  logic signed [15:0] grav_x_r, grav_y_r, grav_z_r, roll_r;
  logic signed [14:0] pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grav_x_r <= e_grav[47:32];
      grav_y_r <= e_grav[31:16];
      grav_z_r <= e_grav[15:0];
      roll_r   <= r_cl[15:0];
      pitch_r  <= p_cl[14:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_grav_x      = grav_x_r;
  assign out_grav_y      = grav_y_r;
  assign out_grav_z      = grav_z_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;

endmodule
